// ===== hw/rtl/sdtq_pkg.sv =====
// Shared constants, types and codes of the sorted deadline timer queue.
package sdtq_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int DL_W      = 32;

  localparam logic [1:0] FN_TICK   = 2'd0;
  localparam logic [1:0] FN_ADD    = 2'd1;
  localparam logic [1:0] FN_SET    = 2'd2;
  localparam logic [1:0] FN_DELETE = 2'd3;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t         op;
    logic [DL_W-1:0] a;
    logic [DL_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [DL_W-1:0] sum;
    logic            carry;  // carry out on add, borrow on subtract
    logic            zero;
  } alu_rsp_t;

endpackage

// ===== hw/rtl/sdtq_alu.sv =====
// Shared 32-bit add/subtract unit used for tick increments, wrap checks, rebasing and compares.
module sdtq_alu (
  input  sdtq_pkg::alu_req_t req,
  output sdtq_pkg::alu_rsp_t rsp
);
  import sdtq_pkg::*;

  logic [DL_W:0] wide;

  always_comb begin
    if (req.op == ALU_SUB) begin
      wide = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      wide = {1'b0, req.a} + {1'b0, req.b};
    end
    rsp.sum   = wide[DL_W-1:0];
    rsp.carry = wide[DL_W];
    rsp.zero  = (wide[DL_W-1:0] == '0);
  end

endmodule

// ===== hw/rtl/sdtq_dl_mem.sv =====
// Deadline store: one write port, one registered read port.
module sdtq_dl_mem (
  input  logic                            clk,
  input  logic                            we,
  input  logic [sdtq_pkg::SLOT_W-1:0]     waddr,
  input  logic [sdtq_pkg::DL_W-1:0]       wdata,
  input  logic [sdtq_pkg::SLOT_W-1:0]     raddr,
  output logic [sdtq_pkg::DL_W-1:0]       rdata
);
  import sdtq_pkg::*;

  logic [DL_W-1:0] mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sorted_deadline_timer_queue_top.sv =====
// Sorted deadline timer queue: sequencer over a shared ALU and a deadline RAM.
// A tick scans the pending list and emits one expiry word per expired slot; add/set
// checks for wrap, rebases all pending deadlines on a wrap, writes the deadline and scans
// for its sorted place; delete and refused operations go straight to the acknowledge.
// One word is taken at a time, only in idle; a stalled output holds the sequencer.
// Reset (rst, synchronous) empties both lists, frees all slots, zeros the count.
module sorted_deadline_timer_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // slot_index[3:0], delay_ticks[35:4], zero pad
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // ok[0], slot_out[4:1], tick_count[36:5], zero pad
  output logic [0:0]  m_tuser,   // result_kind[0]
  output logic        m_tlast
);
  import sdtq_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DECODE   = 13'b0000000000010,
    S_WRAP     = 13'b0000000000100,
    S_RB_RD    = 13'b0000000001000,
    S_RB_WR    = 13'b0000000010000,
    S_WR       = 13'b0000000100000,
    S_SC_RD    = 13'b0000001000000,
    S_SC_CMP   = 13'b0000010000000,
    S_TICK_RD  = 13'b0000100000000,
    S_TICK_CMP = 13'b0001000000000,
    S_EMIT     = 13'b0010000000000,
    S_SHIFT    = 13'b0100000000000,
    S_OUT      = 13'b1000000000000
  } state_t;

  state_t state;

  logic [1:0]        func_q;
  logic [3:0]        slot_q;
  logic [DL_W-1:0]   delay_q;
  logic [DL_W-1:0]   now;
  logic [DL_W-1:0]   dnew;
  logic              busy [NUM_SLOTS];
  logic              expd [NUM_SLOTS];
  logic [SLOT_W-1:0] po   [NUM_SLOTS];
  logic [SLOT_W-1:0] eo   [NUM_SLOTS];
  logic [CNT_W-1:0]  pc;
  logic [CNT_W-1:0]  ec;
  logic [SLOT_W-1:0] ap;
  logic [SLOT_W-1:0] sel;
  logic              mv;
  logic [CNT_W-1:0]  pos_p;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  dcnt;
  logic              res_ok;
  logic [3:0]        res_slot;

  alu_req_t          areq;
  alu_rsp_t          arsp;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [DL_W-1:0]   mem_wdata;
  logic [DL_W-1:0]   rdata;
  logic [SLOT_W-1:0] idx_lo;

  logic              free_found;
  logic [SLOT_W-1:0] free_s;
  logic [SLOT_W-1:0] cand;
  logic              p_found;
  logic [CNT_W-1:0]  p_pos;
  logic              e_found;
  logic [CNT_W-1:0]  e_pos;
  logic [SLOT_W-1:0] slot_lo;
  logic              slot_oor;
  logic              out_free;
  logic              out_load;
  logic              sc_hit;

  logic [SLOT_W-1:0] rm_po  [NUM_SLOTS];
  logic [SLOT_W-1:0] ins_po [NUM_SLOTS];
  logic [SLOT_W-1:0] sh_po  [NUM_SLOTS];
  logic [SLOT_W-1:0] re_eo  [NUM_SLOTS];

  sdtq_alu u_alu (
    .req (areq),
    .rsp (arsp)
  );

  sdtq_dl_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (po[idx_lo]),
    .rdata (rdata)
  );

  assign idx_lo   = idx[SLOT_W-1:0];
  assign slot_lo  = slot_q[SLOT_W-1:0];
  assign slot_oor = (32'(slot_q) >= NUM_SLOTS);
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (state == S_EMIT || state == S_OUT);
  assign sc_hit   = arsp.carry || ((idx >= pos_p) && arsp.zero);

  // Pick the shared unit's operands for the current step.
  always_comb begin
    areq.op = ALU_ADD;
    areq.a  = now;
    areq.b  = 32'd1;
    unique case (state)
      S_WRAP: begin
        areq.a = delay_q;
        areq.b = now;
      end
      S_RB_WR: begin
        areq.op = ALU_SUB;
        areq.a  = rdata;
        areq.b  = now;
      end
      S_SC_CMP: begin
        areq.op = ALU_SUB;
        areq.a  = dnew;
        areq.b  = rdata;
      end
      S_TICK_CMP: begin
        areq.op = ALU_SUB;
        areq.a  = now;
        areq.b  = rdata;
      end
      default: begin
        areq.op = ALU_ADD;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sel;
    mem_wdata = dnew;
    if (state == S_RB_WR) begin
      mem_we    = 1'b1;
      mem_waddr = po[idx_lo];
      mem_wdata = arsp.sum;
    end else if (state == S_WR) begin
      mem_we = 1'b1;
    end
  end

  // Round-robin free slot, and positions of the addressed slot in both lists.
  always_comb begin
    free_found = 1'b0;
    free_s     = '0;
    cand       = '0;
    p_found    = 1'b0;
    p_pos      = '0;
    e_found    = 1'b0;
    e_pos      = '0;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      cand = ap + SLOT_W'(k);
      if (!busy[cand]) begin
        free_found = 1'b1;
        free_s     = cand;
      end
    end
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (CNT_W'(i) < pc && po[i] == slot_lo) begin
        p_found = 1'b1;
        p_pos   = CNT_W'(i);
      end
      if (CNT_W'(i) < ec && eo[i] == slot_lo) begin
        e_found = 1'b1;
        e_pos   = CNT_W'(i);
      end
    end
  end

  // List edits: drop at pos_p, insert at idx, drop the first dcnt, drop at e_pos.
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (CNT_W'(i) < pos_p || i == NUM_SLOTS - 1) begin
        rm_po[i] = po[i];
      end else begin
        rm_po[i] = po[(i + 1) % NUM_SLOTS];
      end
      if (CNT_W'(i) < idx) begin
        ins_po[i] = po[i];
      end else if (CNT_W'(i) == idx) begin
        ins_po[i] = sel;
      end else begin
        ins_po[i] = po[(i + NUM_SLOTS - 1) % NUM_SLOTS];
      end
      if (32'(i) + 32'(dcnt) < NUM_SLOTS) begin
        sh_po[i] = po[(32'(i) + 32'(dcnt)) % NUM_SLOTS];
      end else begin
        sh_po[i] = po[i];
      end
      if (CNT_W'(i) < e_pos || i == NUM_SLOTS - 1) begin
        re_eo[i] = eo[i];
      end else begin
        re_eo[i] = eo[(i + 1) % NUM_SLOTS];
      end
    end
  end

  // Output valid: load a new word, or drop the one taken by the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      now      <= '0;
      pc       <= '0;
      ec       <= '0;
      ap       <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        busy[i] <= 1'b0;
        expd[i] <= 1'b0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func_q  <= s_tuser;
            slot_q  <= s_tdata[3:0];
            delay_q <= s_tdata[35:4];
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (func_q)
            FN_TICK: begin
              now      <= arsp.sum;
              idx      <= '0;
              res_ok   <= 1'b1;
              res_slot <= '0;
              state    <= S_TICK_RD;
            end
            FN_ADD: begin
              res_ok <= 1'b0;
              if (!free_found || pc >= CNT_W'(NUM_SLOTS)) begin
                res_slot <= '0;
                state    <= S_OUT;
              end else begin
                sel          <= free_s;
                res_slot     <= 4'(free_s);
                mv           <= 1'b0;
                pos_p        <= pc;
                busy[free_s] <= 1'b1;
                expd[free_s] <= 1'b0;
                ap           <= free_s + SLOT_W'(1);
                state        <= S_WRAP;
              end
            end
            FN_SET: begin
              res_ok   <= 1'b0;
              res_slot <= slot_q;
              if (!slot_oor && busy[slot_lo] && expd[slot_lo]) begin
                if (e_found) begin
                  eo <= re_eo;
                  ec <= ec - CNT_W'(1);
                end
                if (e_found && pc < CNT_W'(NUM_SLOTS)) begin
                  expd[slot_lo] <= 1'b0;
                  sel           <= slot_lo;
                  mv            <= 1'b0;
                  pos_p         <= pc;
                  state         <= S_WRAP;
                end else begin
                  state <= S_OUT;
                end
              end else if (!slot_oor && busy[slot_lo] && p_found) begin
                sel   <= slot_lo;
                mv    <= 1'b1;
                pos_p <= p_pos;
                state <= S_WRAP;
              end else begin
                state <= S_OUT;
              end
            end
            FN_DELETE: begin
              res_slot <= slot_q;
              state    <= S_OUT;
              if (!slot_oor && busy[slot_lo] && expd[slot_lo] && e_found) begin
                eo            <= re_eo;
                ec            <= ec - CNT_W'(1);
                busy[slot_lo] <= 1'b0;
                expd[slot_lo] <= 1'b0;
                res_ok        <= 1'b1;
              end else begin
                res_ok <= 1'b0;
              end
            end
            default: begin
              res_ok   <= 1'b0;
              res_slot <= slot_q;
              state    <= S_OUT;
            end
          endcase
        end
        S_WRAP: begin
          idx <= '0;
          if (arsp.carry) begin
            state <= S_RB_RD;
          end else begin
            dnew  <= arsp.sum;
            state <= S_WR;
          end
        end
        S_RB_RD: begin
          if (idx == pc) begin
            now   <= '0;
            dnew  <= delay_q;
            state <= S_WR;
          end else begin
            state <= S_RB_WR;
          end
        end
        S_RB_WR: begin
          idx   <= idx + CNT_W'(1);
          state <= S_RB_RD;
        end
        S_WR: begin
          if (mv) begin
            po <= rm_po;
            pc <= pc - CNT_W'(1);
          end
          idx   <= '0;
          state <= S_SC_RD;
        end
        S_SC_RD: begin
          if (idx == pc) begin
            po     <= ins_po;
            pc     <= pc + CNT_W'(1);
            res_ok <= 1'b1;
            state  <= S_OUT;
          end else begin
            state <= S_SC_CMP;
          end
        end
        S_SC_CMP: begin
          if (sc_hit) begin
            po     <= ins_po;
            pc     <= pc + CNT_W'(1);
            res_ok <= 1'b1;
            state  <= S_OUT;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= S_SC_RD;
          end
        end
        S_TICK_RD: begin
          if (idx == pc || idx == CNT_W'(NUM_SLOTS)) begin
            dcnt  <= idx;
            idx   <= '0;
            state <= (idx == '0) ? S_OUT : S_EMIT;
          end else begin
            state <= S_TICK_CMP;
          end
        end
        S_TICK_CMP: begin
          if (!arsp.carry) begin
            idx   <= idx + CNT_W'(1);
            state <= S_TICK_RD;
          end else begin
            dcnt  <= idx;
            idx   <= '0;
            state <= (idx == '0) ? S_OUT : S_EMIT;
          end
        end
        S_EMIT: begin
          // Hold until the output register frees up.
          if (out_free) begin
            m_tuser[0] <= KIND_EXPIRY;
            m_tdata    <= {3'b000, now, 4'(po[idx_lo]), 1'b1};
            m_tlast    <= (idx + CNT_W'(1) == dcnt);
            expd[po[idx_lo]] <= 1'b1;
            if (ec < CNT_W'(NUM_SLOTS)) begin
              eo[ec[SLOT_W-1:0]] <= po[idx_lo];
              ec                 <= ec + CNT_W'(1);
            end
            idx <= idx + CNT_W'(1);
            if (idx + CNT_W'(1) == dcnt) begin
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          po    <= sh_po;
          pc    <= pc - dcnt;
          state <= S_IDLE;
        end
        S_OUT: begin
          if (out_free) begin
            m_tuser[0] <= KIND_ACK;
            m_tdata    <= {3'b000, now, res_slot, res_ok};
            m_tlast    <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
